// ===== hw/rtl/lsc_pkg.sv =====
// shared types and constants for the lifo stack with palindrome check
// no dependencies; imported by every module of the block
package lsc_pkg;

    // default stack depth and width of the reported entry count
    localparam int STACK_DEPTH_DEF = 16;
    localparam int WORD_W          = 32;
    localparam int COUNT_OUT_W     = 5;

    // request opcodes
    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_PALIN = 3'd4
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_OVERFLOW = 2'd1,
        STS_EMPTY    = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_CMP
    } t_state;

    // what the stack word of every cell does this cycle
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_PUSH,
        SH_POP,
        SH_ROT
    } t_shift;

    // what the mirror word of every cell does this cycle
    typedef enum logic [1:0] {
        RV_HOLD,
        RV_LOAD,
        RV_SCAN
    } t_rev;

    // control broadcast from the controller to the cell row
    typedef struct packed {
        t_shift shift;
        t_rev   rev;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/lsc_cell.sv =====
// one stack cell: a stack word and a mirror word, each passed to neighbors
// depends on lsc_pkg
module lsc_cell import lsc_pkg::*; #(
    parameter int IDX     = 0,
    parameter int COUNT_W = 5
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [WORD_W-1:0]   i_from_prev,
    input  logic [WORD_W-1:0]   i_from_next,
    input  logic [WORD_W-1:0]   i_wrap,
    input  logic [WORD_W-1:0]   i_rev_prev,
    input  logic [WORD_W-1:0]   i_rev_next,
    output logic [WORD_W-1:0]   o_word,
    output logic [WORD_W-1:0]   o_rev
);

    logic [WORD_W-1:0] r_word, n_word;
    logic [WORD_W-1:0] r_rev, n_rev;
    logic              w_in_use;
    logic              w_is_last;

    // position of this cell within the occupied part of the stack
    assign w_in_use  = COUNT_W'(IDX) < i_count;
    assign w_is_last = COUNT_W'(IDX + 1) == i_count;

    // stack word: push moves down, pop moves up, rotate wraps the top to the bottom
    always_comb begin
        n_word = r_word;
        case (i_ctl.shift)
            SH_HOLD: n_word = r_word;
            SH_PUSH: n_word = i_from_prev;
            SH_POP:  n_word = i_from_next;
            SH_ROT: begin
                if (w_is_last) begin
                    n_word = i_wrap;
                end else if (w_in_use) begin
                    n_word = i_from_next;
                end
            end
            default: n_word = r_word;
        endcase
    end

    // mirror word: load shifts down from the top, scan shifts back up
    always_comb begin
        n_rev = r_rev;
        case (i_ctl.rev)
            RV_HOLD: n_rev = r_rev;
            RV_LOAD: n_rev = i_rev_prev;
            RV_SCAN: n_rev = i_rev_next;
            default: n_rev = r_rev;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_rev  <= n_rev;
    end

    assign o_word = r_word;
    assign o_rev  = r_rev;

endmodule

// ===== hw/rtl/lsc_ctrl.sv =====
// controller: entry count, opcode decode, palindrome sequencing, result registers
// depends on lsc_pkg
module lsc_ctrl import lsc_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int COUNT_W     = $clog2(STACK_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_opcode,
    input  logic [WORD_W-1:0]       i_top_word,
    input  logic [WORD_W-1:0]       i_top_rev,
    output t_cell_ctl               o_ctl,
    output logic [COUNT_W-1:0]      o_count,
    output logic                    o_result_valid,
    output logic [WORD_W-1:0]       o_data_word,
    output logic [1:0]              o_status,
    output logic                    o_palindrome_flag,
    output logic [COUNT_OUT_W-1:0]  o_entry_count_out
);

    localparam logic [COUNT_W-1:0] FULL = COUNT_W'(STACK_DEPTH);
    localparam logic [COUNT_W-1:0] ONE  = COUNT_W'(1);

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_step, n_step;
    logic               r_match, n_match;
    logic               r_valid, n_valid;
    logic [WORD_W-1:0]  r_data, n_data;
    t_status            r_status, n_status;
    logic               r_flag, n_flag;

    logic w_accept;
    logic w_last_step;
    logic w_eq;

    assign w_accept    = start && (r_state == S_IDLE);
    assign w_last_step = r_step == (r_count - ONE);
    assign w_eq        = i_top_word == i_top_rev;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (t_opcode'(i_opcode) == OP_PALIN) && (r_count != '0)) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (w_last_step) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_last_step) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control and result
    always_comb begin
        o_ctl    = '{shift: SH_HOLD, rev: RV_HOLD};
        n_count  = r_count;
        n_step   = r_step;
        n_match  = r_match;
        n_valid  = 1'b0;
        n_data   = '0;
        n_status = STS_OK;
        n_flag   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    case (t_opcode'(i_opcode))
                        OP_PUSH: begin
                            if (r_count == FULL) begin
                                n_status = STS_OVERFLOW;
                            end else begin
                                o_ctl.shift = SH_PUSH;
                                n_count     = r_count + ONE;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                o_ctl.shift = SH_POP;
                                n_data      = i_top_word;
                                n_count     = r_count - ONE;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_data = i_top_word;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_PALIN: begin
                            if (r_count == '0) begin
                                n_flag = 1'b1;
                            end else begin
                                // start the mirror fill; the result comes at the end of the scan
                                n_valid   = 1'b0;
                                n_step    = '0;
                                n_match   = 1'b1;
                                o_ctl.shift = SH_ROT;
                                o_ctl.rev   = RV_LOAD;
                                n_step    = ONE;
                                if (r_count == ONE) begin
                                    n_step = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // finish rotating the stack once round while the mirror row fills in reverse
            S_FILL: begin
                o_ctl.shift = SH_ROT;
                o_ctl.rev   = RV_LOAD;
                n_step      = w_last_step ? '0 : r_step + ONE;
            end
            // rotate again, comparing the top word with the mirror head each cycle
            S_CMP: begin
                o_ctl.shift = SH_ROT;
                o_ctl.rev   = RV_SCAN;
                n_match     = r_match && w_eq;
                n_step      = w_last_step ? '0 : r_step + ONE;
                if (w_last_step) begin
                    n_valid = 1'b1;
                    n_flag  = r_match && w_eq;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // sequencing and result payload
    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_match  <= n_match;
        r_data   <= n_data;
        r_status <= n_status;
        r_flag   <= n_flag;
    end

    assign busy              = r_state != S_IDLE;
    assign o_count           = r_count;
    assign o_result_valid    = r_valid;
    assign o_data_word       = r_data;
    assign o_status          = r_status;
    assign o_palindrome_flag = r_flag;
    assign o_entry_count_out = COUNT_OUT_W'(r_count);

endmodule

// ===== hw/rtl/lifo_stack_with_palindrome_check_unit.sv =====
// top level: controller plus a row of stack cells with the top word in cell 0
// depends on lsc_pkg, lsc_ctrl, lsc_cell
//
// A request is taken when start is high and busy is low, and every request
// gives exactly one result, shown for one cycle with o_result_valid high;
// the receiver cannot stall it. Push, pop, peek, clear and the unused
// opcodes give their result in the cycle after the request, and busy
// stays low, so a new request can be issued every cycle. The stack is a
// row of cells with the top word in the first cell whenever busy is low,
// so push and pop are one shift of the whole row. A palindrome check on a
// non-empty stack keeps busy high after the request (on an empty stack
// busy stays low) while the occupied cells rotate once round, starting in
// the request cycle, to load a mirror row in reverse order, then once more
// while the top word is compared with the head of the mirror row; the
// result appears in the first cycle with busy low again and the stack is
// left as it was. Stack contents need no clearing after reset.
module lifo_stack_with_palindrome_check_unit import lsc_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_opcode,
    input  logic [WORD_W-1:0]       i_push_value,
    output logic                    o_result_valid,
    output logic [WORD_W-1:0]       o_data_word,
    output logic [1:0]              o_status,
    output logic                    o_palindrome_flag,
    output logic [COUNT_OUT_W-1:0]  o_entry_count_out
);

    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

    t_cell_ctl          w_ctl;
    logic [COUNT_W-1:0] w_count;
    logic [WORD_W-1:0]  w_word [STACK_DEPTH];
    logic [WORD_W-1:0]  w_rev  [STACK_DEPTH];

    // controller
    lsc_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .COUNT_W     (COUNT_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_top_word        (w_word[0]),
        .i_top_rev         (w_rev[0]),
        .o_ctl             (w_ctl),
        .o_count           (w_count),
        .o_result_valid    (o_result_valid),
        .o_data_word       (o_data_word),
        .o_status          (o_status),
        .o_palindrome_flag (o_palindrome_flag),
        .o_entry_count_out (o_entry_count_out)
    );

    // row of cells; the first cell takes pushed data and feeds the mirror row
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_prev, w_next, w_rprev, w_rnext;

        if (g == 0) begin : g_head
            assign w_prev  = i_push_value;
            assign w_rprev = w_word[0];
        end else begin : g_body
            assign w_prev  = w_word[g-1];
            assign w_rprev = w_rev[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_next  = '0;
            assign w_rnext = '0;
        end else begin : g_inner
            assign w_next  = w_word[g+1];
            assign w_rnext = w_rev[g+1];
        end

        lsc_cell #(
            .IDX     (g),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (w_count),
            .i_from_prev (w_prev),
            .i_from_next (w_next),
            .i_wrap      (w_word[0]),
            .i_rev_prev  (w_rprev),
            .i_rev_next  (w_rnext),
            .o_word      (w_word[g]),
            .o_rev       (w_rev[g])
        );
    end

endmodule

// ===== hw/rtl/lsc_checker.sv =====
// port-level checks for the lifo stack with palindrome check, bound to the top
// depends on lsc_pkg and lifo_stack_with_palindrome_check_unit
module lsc_checker import lsc_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [2:0]              i_opcode,
    input logic                    o_result_valid,
    input logic [1:0]              o_status,
    input logic                    o_palindrome_flag,
    input logic [COUNT_OUT_W-1:0]  o_entry_count_out
);

    // requests other than a palindrome check answer in the next cycle with busy low
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode != OP_PALIN)) |=> (o_result_valid && !busy))
        else $error("single-cycle request gave no result in the next cycle");

    // the end of a palindrome scan delivers its result
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("palindrome scan ended without a result");

    // a set flag only ever comes with a valid ok result
    a_flag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_palindrome_flag |-> (o_result_valid && (o_status == STS_OK)))
        else $error("palindrome flag outside an ok result");

    // overflow only on a full stack
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == STS_OVERFLOW))
            |-> (o_entry_count_out == COUNT_OUT_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    // empty status only on an empty stack
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == STS_EMPTY)) |-> (o_entry_count_out == '0))
        else $error("empty status reported with entries present");

endmodule

bind lifo_stack_with_palindrome_check_unit lsc_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_lsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_opcode          (i_opcode),
    .o_result_valid    (o_result_valid),
    .o_status          (o_status),
    .o_palindrome_flag (o_palindrome_flag),
    .o_entry_count_out (o_entry_count_out)
);
